// ===== rtl/core/hdub_pkg.sv =====
// Shared constants, codes and structures of the half-duplex serial bus controller.
// Depends on nothing; every other file of the block uses it by scoped name.
package hdub_pkg;

    localparam int FRAME_SLOTS = 4;
    localparam int FRAME_BYTES = 32;

    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 6;
    localparam int SLOT_W    = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int TX_IDX_W  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int RX_ADDR_W = (FRAME_SLOTS * FRAME_BYTES > 1) ?
                               $clog2(FRAME_SLOTS * FRAME_BYTES) : 1;

    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_RX_BYTE   = 2'd0,
        CMD_LINE_IDLE = 2'd1,
        CMD_TX_EMPTY  = 2'd2,
        CMD_SEND_BYTE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_RX    = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CLOSE_NONE    = 2'd0,
        CLOSE_EMPTY   = 2'd1,
        CLOSE_DELIVER = 2'd2
    } close_t;

    typedef struct packed {
        logic                 rx_wr;
        logic                 tx_wr;
        logic [RX_ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0]    wr_data;
        close_t               close;
        logic [SLOT_W-1:0]    slot;
        logic [CNT_W-1:0]     count;
        logic                 send;
        logic [CNT_W-1:0]     send_pos;
        logic                 txie;
    } op_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  frame_length;
        logic              txie;
        logic              last;
    } result_t;

endpackage

// ===== rtl/core/hdub_front.sv =====
// Front end: accepts bus events, keeps the framing and transmit control state,
// and classifies each beat into a back-end operation. Depends on hdub_pkg.
module hdub_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [1:0]                  cmd,
    input  logic [hdub_pkg::BYTE_W-1:0] data_byte,
    input  logic                        send_last,
    output logic                        op_valid,
    output hdub_pkg::op_t               op
);

    typedef enum logic [2:0] {
        LOAD_IDLE = 3'b001,
        LOAD_BUSY = 3'b010,
        LOAD_DROP = 3'b100
    } load_state_t;

    logic [hdub_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [hdub_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                        ovf_reg, ovf_next;
    logic [hdub_pkg::CNT_W-1:0]  position_reg, position_next;
    logic [hdub_pkg::CNT_W-1:0]  length_reg, length_next;
    logic [hdub_pkg::CNT_W-1:0]  load_cnt_reg, load_cnt_next;
    logic                        bus_free_reg, bus_free_next;
    logic                        waiting_reg, waiting_next;
    logic                        running_reg, running_next;
    load_state_t                 load_reg, load_next;

    always_comb
    begin
        slot_next     = slot_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        position_next = position_reg;
        length_next   = length_reg;
        load_cnt_next = load_cnt_reg;
        bus_free_next = bus_free_reg;
        waiting_next  = waiting_reg;
        running_next  = running_reg;
        load_next     = load_reg;
        op            = '0;
        op.close      = hdub_pkg::CLOSE_NONE;
        op.wr_data    = data_byte;
        op_valid      = 1'b0;
        unique case (hdub_pkg::cmd_t'(cmd))
            hdub_pkg::CMD_RX_BYTE:
            begin
                if (count_reg < hdub_pkg::CNT_W'(hdub_pkg::FRAME_BYTES))
                begin
                    op.rx_wr   = 1'b1;
                    op.wr_addr = hdub_pkg::RX_ADDR_W'(slot_reg)
                               * hdub_pkg::RX_ADDR_W'(hdub_pkg::FRAME_BYTES)
                               + hdub_pkg::RX_ADDR_W'(count_reg);
                    count_next = count_reg + 1'b1;
                    op_valid   = 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            hdub_pkg::CMD_LINE_IDLE:
            begin
                if (!ovf_reg)
                begin
                    op.close = (count_reg == '0) ? hdub_pkg::CLOSE_EMPTY
                                                 : hdub_pkg::CLOSE_DELIVER;
                    op.slot  = slot_reg;
                    op.count = count_reg;
                    op_valid = 1'b1;
                end
                slot_next  = (slot_reg == hdub_pkg::SLOT_W'(hdub_pkg::FRAME_SLOTS - 1))
                           ? '0 : slot_reg + 1'b1;
                count_next = '0;
                ovf_next   = 1'b0;
                if (waiting_reg)
                begin
                    running_next  = 1'b1;
                    waiting_next  = 1'b0;
                    op.send       = 1'b1;
                    op.send_pos   = position_reg;
                    position_next = position_reg + 1'b1;
                    op_valid      = 1'b1;
                end
                else
                begin
                    bus_free_next = 1'b1;
                end
            end
            hdub_pkg::CMD_TX_EMPTY:
            begin
                if (running_reg)
                begin
                    if (position_reg < length_reg)
                    begin
                        op.send       = 1'b1;
                        op.send_pos   = position_reg;
                        position_next = position_reg + 1'b1;
                        op_valid      = 1'b1;
                    end
                    else
                    begin
                        bus_free_next = 1'b1;
                        running_next  = 1'b0;
                    end
                end
            end
            hdub_pkg::CMD_SEND_BYTE:
            begin
                if (load_reg == LOAD_IDLE)
                begin
                    load_cnt_next = '0;
                    load_next     = (running_reg || waiting_reg) ? LOAD_DROP : LOAD_BUSY;
                end
                if (load_next == LOAD_BUSY)
                begin
                    if (load_cnt_next < hdub_pkg::CNT_W'(hdub_pkg::FRAME_BYTES))
                    begin
                        op.tx_wr      = 1'b1;
                        op.wr_addr    = hdub_pkg::RX_ADDR_W'(load_cnt_next);
                        load_cnt_next = load_cnt_next + 1'b1;
                        op_valid      = 1'b1;
                    end
                    if (send_last)
                    begin
                        length_next   = load_cnt_next;
                        position_next = '0;
                        load_next     = LOAD_IDLE;
                        if (bus_free_reg)
                        begin
                            bus_free_next = 1'b0;
                            running_next  = 1'b1;
                            op.send       = 1'b1;
                            op.send_pos   = '0;
                            position_next = hdub_pkg::CNT_W'(1);
                            op_valid      = 1'b1;
                        end
                        else
                        begin
                            waiting_next = 1'b1;
                        end
                    end
                end
                else if (send_last)
                begin
                    load_next = LOAD_IDLE;
                end
            end
        endcase
        op.txie = running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            position_reg <= '0;
            length_reg   <= '0;
            load_cnt_reg <= '0;
            bus_free_reg <= 1'b1;
            waiting_reg  <= 1'b0;
            running_reg  <= 1'b0;
            load_reg     <= LOAD_IDLE;
        end
        else if (accept)
        begin
            slot_reg     <= slot_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            position_reg <= position_next;
            length_reg   <= length_next;
            load_cnt_reg <= load_cnt_next;
            bus_free_reg <= bus_free_next;
            waiting_reg  <= waiting_next;
            running_reg  <= running_next;
            load_reg     <= load_next;
        end
    end

endmodule

// ===== rtl/core/hdub_cmd_queue.sv =====
// Short operation queue between the front end and the back end.
// Depends on hdub_pkg for the operation structure and depth.
module hdub_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hdub_pkg::op_t din,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output hdub_pkg::op_t head
);

    hdub_pkg::op_t                 mem [hdub_pkg::Q_DEPTH];
    logic [hdub_pkg::Q_PTR_W-1:0]  wptr_reg;
    logic [hdub_pkg::Q_PTR_W-1:0]  rptr_reg;
    logic [hdub_pkg::Q_CNT_W-1:0]  count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (count_reg == hdub_pkg::Q_CNT_W'(hdub_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + hdub_pkg::Q_CNT_W'(do_push)
                                   - hdub_pkg::Q_CNT_W'(do_pop);
        end
    end

endmodule

// ===== rtl/core/hdub_back.sv =====
// Back end: holds the frame ring and message buffer, carries out queued operations, walks
// stored bytes one per cycle while result space lasts and queues results. Depends on hdub_pkg.
module hdub_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  hdub_pkg::op_t     op,
    output logic              op_pop,
    input  logic              pop,
    output logic              empty,
    output hdub_pkg::result_t result
);

    typedef enum logic [2:0] {
        BK_IDLE  = 3'b001,
        BK_CLOSE = 3'b010,
        BK_SEND  = 3'b100
    } back_state_t;

    logic [hdub_pkg::BYTE_W-1:0] rx_mem [hdub_pkg::FRAME_SLOTS * hdub_pkg::FRAME_BYTES];
    logic [hdub_pkg::BYTE_W-1:0] tx_mem [hdub_pkg::FRAME_BYTES];
    logic [hdub_pkg::BYTE_W-1:0] rx_rd_reg;
    logic [hdub_pkg::BYTE_W-1:0] tx_rd_reg;
    logic [hdub_pkg::RX_ADDR_W-1:0] rx_rd_addr;
    logic [hdub_pkg::TX_IDX_W-1:0]  tx_rd_addr;

    back_state_t                 state_reg, state_next;
    hdub_pkg::close_t            close_reg, close_next;
    logic [hdub_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [hdub_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                        send_reg, send_next;
    logic [hdub_pkg::CNT_W-1:0]  pos_reg, pos_next;
    logic                        txie_reg, txie_next;
    logic [hdub_pkg::CNT_W-1:0]  j_reg, j_next;

    logic                        issue;
    logic                        last_byte;
    hdub_pkg::result_t           iss_meta;
    logic                        s2_valid_reg;
    hdub_pkg::result_t           s2_meta_reg;
    logic                        s2_zero_reg;
    hdub_pkg::result_t           s2_result;

    hdub_pkg::result_t              ofifo [hdub_pkg::OUT_DEPTH];
    logic [hdub_pkg::OUT_PTR_W-1:0] owptr_reg;
    logic [hdub_pkg::OUT_PTR_W-1:0] orptr_reg;
    logic [hdub_pkg::OUT_CNT_W-1:0] ocount_reg;
    logic                           can_issue;
    logic                           do_opop;

    assign can_issue = (ocount_reg + hdub_pkg::OUT_CNT_W'(s2_valid_reg))
                     < hdub_pkg::OUT_CNT_W'(hdub_pkg::OUT_DEPTH);
    assign op_pop    = (state_reg == BK_IDLE) && op_valid;
    assign last_byte = (j_reg == count_reg - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        close_next = close_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        send_next  = send_reg;
        pos_next   = pos_reg;
        txie_next  = txie_reg;
        j_next     = j_reg;
        issue      = 1'b0;
        iss_meta   = '0;
        iss_meta.kind = hdub_pkg::KIND_TX;
        iss_meta.txie = txie_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (op_valid)
                begin
                    close_next = op.close;
                    slot_next  = op.slot;
                    count_next = op.count;
                    send_next  = op.send;
                    pos_next   = op.send_pos;
                    txie_next  = op.txie;
                    j_next     = '0;
                    if (op.close != hdub_pkg::CLOSE_NONE)
                    begin
                        state_next = BK_CLOSE;
                    end
                    else if (op.send)
                    begin
                        state_next = BK_SEND;
                    end
                end
            end
            BK_CLOSE:
            begin
                if (can_issue)
                begin
                    issue = 1'b1;
                    if (close_reg == hdub_pkg::CLOSE_EMPTY)
                    begin
                        iss_meta.kind = hdub_pkg::KIND_EMPTY;
                        iss_meta.last = !send_reg;
                        state_next    = send_reg ? BK_SEND : BK_IDLE;
                    end
                    else
                    begin
                        iss_meta.kind         = hdub_pkg::KIND_RX;
                        iss_meta.frame_length = count_reg;
                        iss_meta.last         = last_byte && !send_reg;
                        j_next                = j_reg + 1'b1;
                        if (last_byte)
                        begin
                            state_next = send_reg ? BK_SEND : BK_IDLE;
                        end
                    end
                end
            end
            BK_SEND:
            begin
                if (can_issue)
                begin
                    issue         = 1'b1;
                    iss_meta.kind = hdub_pkg::KIND_TX;
                    iss_meta.last = 1'b1;
                    state_next    = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign rx_rd_addr = hdub_pkg::RX_ADDR_W'(slot_reg)
                      * hdub_pkg::RX_ADDR_W'(hdub_pkg::FRAME_BYTES)
                      + hdub_pkg::RX_ADDR_W'(j_reg);
    assign tx_rd_addr = pos_reg[hdub_pkg::TX_IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (op_pop && op.rx_wr)
        begin
            rx_mem[op.wr_addr] <= op.wr_data;
        end
        rx_rd_reg <= rx_mem[rx_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (op_pop && op.tx_wr)
        begin
            tx_mem[op.wr_addr[hdub_pkg::TX_IDX_W-1:0]] <= op.wr_data;
        end
        tx_rd_reg <= tx_mem[tx_rd_addr];
    end

    always_comb
    begin
        s2_result = s2_meta_reg;
        case (s2_meta_reg.kind)
            hdub_pkg::KIND_RX: s2_result.data = rx_rd_reg;
            hdub_pkg::KIND_TX: s2_result.data = s2_zero_reg ? '0 : tx_rd_reg;
            default:           s2_result.data = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        close_reg   <= close_next;
        slot_reg    <= slot_next;
        count_reg   <= count_next;
        send_reg    <= send_next;
        pos_reg     <= pos_next;
        txie_reg    <= txie_next;
        j_reg       <= j_next;
        s2_meta_reg <= iss_meta;
        s2_zero_reg <= (pos_reg >= hdub_pkg::CNT_W'(hdub_pkg::FRAME_BYTES));
        if (s2_valid_reg)
        begin
            ofifo[owptr_reg] <= s2_result;
        end
    end

    assign empty   = (ocount_reg == '0);
    assign do_opop = pop && !empty;
    assign result  = ofifo[orptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            s2_valid_reg <= 1'b0;
            owptr_reg    <= '0;
            orptr_reg    <= '0;
            ocount_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            s2_valid_reg <= issue;
            if (s2_valid_reg)
            begin
                owptr_reg <= owptr_reg + 1'b1;
            end
            if (do_opop)
            begin
                orptr_reg <= orptr_reg + 1'b1;
            end
            ocount_reg <= ocount_reg + hdub_pkg::OUT_CNT_W'(s2_valid_reg)
                                     - hdub_pkg::OUT_CNT_W'(do_opop);
        end
    end

endmodule

// ===== rtl/core/half_duplex_uart_bus_controller_top.sv =====
// A beat's first result passes the command queue, back-end dequeue, s2 issue register and
// result queue before it is poppable. The back end takes an operation only in BK_IDLE, then
// issues its frame bytes through the single frame-ring read port and then any send it
// starts, pausing while the result queue is full. Reset: rst_n clears the front end, queue
// pointers and back-end state; other back-end registers, ring and buffer are never cleared.
module half_duplex_uart_bus_controller_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  cmd,
    input  logic [hdub_pkg::BYTE_W-1:0] data_byte,
    input  logic                        send_last,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  kind,
    output logic [hdub_pkg::BYTE_W-1:0] out_byte,
    output logic [hdub_pkg::CNT_W-1:0]  frame_length,
    output logic                        tx_int_enable,
    output logic                        last
);

    logic              accept;
    logic              op_valid;
    hdub_pkg::op_t     op;
    logic              q_empty;
    hdub_pkg::op_t     q_head;
    logic              q_pop;
    hdub_pkg::result_t result;

    assign accept = push && !full;

    hdub_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .data_byte (data_byte),
        .send_last (send_last),
        .op_valid  (op_valid),
        .op        (op)
    );

    hdub_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept && op_valid),
        .din   (op),
        .pop   (q_pop),
        .full  (full),
        .empty (q_empty),
        .head  (q_head)
    );

    hdub_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (!q_empty),
        .op       (q_head),
        .op_pop   (q_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

    assign kind          = result.kind;
    assign out_byte      = result.data;
    assign frame_length  = result.frame_length;
    assign tx_int_enable = result.txie;
    assign last          = result.last;

`ifndef SYNTHESIS
    a_tx_keeps_int: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == hdub_pkg::KIND_TX) |-> tx_int_enable)
        else $error("transmit beat without interrupt enable");

    a_empty_notice: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == hdub_pkg::KIND_EMPTY) |-> (out_byte == '0 && frame_length == '0))
        else $error("empty frame notice carries data");

    a_rx_length: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == hdub_pkg::KIND_RX) |-> (frame_length != '0))
        else $error("received frame beat with zero length");
`endif

endmodule

// ===== sim/hdub_bus_checker.sv =====
// Scoreboard for the half-duplex serial bus controller: mirrors the controller's
// frame ring and send buffer, predicts every result beat and compares popped ones.
// Depends on hdub_pkg for the command and result codes and the buffer sizes.
module hdub_bus_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [1:0] cmd,
    input  logic [7:0] data_byte,
    input  logic       send_last,
    input  logic       empty,
    input  logic       pop,
    input  logic [1:0] kind,
    input  logic [7:0] out_byte,
    input  logic [5:0] frame_length,
    input  logic       tx_int_enable,
    input  logic       last,
    output int         mismatches,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = hdub_pkg::FRAME_SLOTS;
    localparam int BYTES = hdub_pkg::FRAME_BYTES;

    typedef enum logic [1:0] {
        LOAD_IDLE = 2'd0,
        LOAD_COPY = 2'd1,
        LOAD_DROP = 2'd2
    } load_mode_t;

    logic [7:0]  rx_store [0:SLOTS*BYTES-1];
    int unsigned rx_slot;
    logic [5:0]  rx_count;
    bit          rx_overflow;
    logic [7:0]  tx_buf [0:BYTES-1];
    logic [5:0]  tx_pos;
    logic [5:0]  tx_len;
    logic [5:0]  load_cnt;
    bit          bus_idle;
    bit          tx_wait;
    bit          tx_busy;
    load_mode_t  load_mode;

    hdub_pkg::result_t step_results [$];
    hdub_pkg::result_t owed_results [$];
    hdub_pkg::result_t want;

    function automatic hdub_pkg::result_t make_result(hdub_pkg::kind_t k, logic [7:0] b,
                                                      logic [5:0] n);
        hdub_pkg::result_t r;
        r.kind         = k;
        r.data         = b;
        r.frame_length = n;
        r.txie         = 1'b0;
        r.last         = 1'b0;
        return r;
    endfunction

    task automatic queue_tx_byte();
        logic [7:0] b;
        b = (tx_pos < BYTES) ? tx_buf[tx_pos] : 8'd0;
        step_results.push_back(make_result(hdub_pkg::KIND_TX, b, 6'd0));
        tx_pos = tx_pos + 1'b1;
    endtask

    task automatic advance_bus(logic [1:0] op, logic [7:0] din, logic fin);
        hdub_pkg::result_t r;
        int j;
        step_results.delete();
        case (op)
            hdub_pkg::CMD_RX_BYTE: begin
                if (rx_count < BYTES) begin
                    rx_store[rx_slot * BYTES + rx_count] = din;
                    rx_count = rx_count + 1'b1;
                end else begin
                    rx_overflow = 1'b1;
                end
            end
            hdub_pkg::CMD_LINE_IDLE: begin
                if (!rx_overflow) begin
                    if (rx_count == 0) begin
                        step_results.push_back(make_result(hdub_pkg::KIND_EMPTY, 8'd0, 6'd0));
                    end else begin
                        for (j = 0; j < rx_count; j++)
                        begin
                            step_results.push_back(make_result(hdub_pkg::KIND_RX,
                                rx_store[rx_slot * BYTES + j], rx_count));
                        end
                    end
                end
                rx_slot     = (rx_slot + 1) % SLOTS;
                rx_count    = '0;
                rx_overflow = 1'b0;
                if (tx_wait) begin
                    tx_busy = 1'b1;
                    tx_wait = 1'b0;
                    queue_tx_byte();
                end else begin
                    bus_idle = 1'b1;
                end
            end
            hdub_pkg::CMD_TX_EMPTY: begin
                if (tx_busy) begin
                    if (tx_pos < tx_len) begin
                        queue_tx_byte();
                    end else begin
                        bus_idle = 1'b1;
                        tx_busy  = 1'b0;
                    end
                end
            end
            default: begin
                if (load_mode == LOAD_IDLE) begin
                    load_cnt  = '0;
                    load_mode = (tx_busy || tx_wait) ? LOAD_DROP : LOAD_COPY;
                end
                if (load_mode == LOAD_COPY) begin
                    if (load_cnt < BYTES) begin
                        tx_buf[load_cnt] = din;
                        load_cnt = load_cnt + 1'b1;
                    end
                    if (fin) begin
                        tx_len    = load_cnt;
                        tx_pos    = '0;
                        load_mode = LOAD_IDLE;
                        if (bus_idle) begin
                            bus_idle = 1'b0;
                            tx_busy  = 1'b1;
                            queue_tx_byte();
                        end else begin
                            tx_wait = 1'b1;
                        end
                    end
                end else if (fin) begin
                    load_mode = LOAD_IDLE;
                end
            end
        endcase
        for (j = 0; j < step_results.size(); j++)
        begin
            r      = step_results[j];
            r.txie = tx_busy;
            r.last = (j == step_results.size() - 1);
            owed_results.push_back(r);
        end
    endtask

    task automatic compare_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rx_slot     = 0;
            rx_count    = '0;
            rx_overflow = 1'b0;
            tx_pos      = '0;
            tx_len      = '0;
            load_cnt    = '0;
            bus_idle    = 1'b1;
            tx_wait     = 1'b0;
            tx_busy     = 1'b0;
            load_mode   = LOAD_IDLE;
            owed_results.delete();
        end else begin
            if (pop && !empty) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected beat: kind %0d out_byte %0d", kind, out_byte);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    compare_field("kind", 8'(want.kind), 8'(kind));
                    compare_field("out_byte", want.data, out_byte);
                    compare_field("frame_length", 8'(want.frame_length), 8'(frame_length));
                    compare_field("tx_int_enable", 8'(want.txie), 8'(tx_int_enable));
                    compare_field("last", 8'(want.last), 8'(last));
                end
            end
            if (push && !full)
                advance_bus(cmd, data_byte, send_last);
        end
        pending = owed_results.size();
    end

endmodule

// ===== sim/tb_half_duplex_uart_bus_controller_top.sv =====
// Stimulus and verdict for the half-duplex serial bus controller: directed events,
// then receive frames, send messages and noise under changing gap and stall rates.
// Depends on hdub_pkg, the controller top and hdub_bus_checker.
module tb_half_duplex_uart_bus_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int PHASE_BEATS    = 100;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    hdub_pkg::cmd_t     cmd = hdub_pkg::CMD_RX_BYTE;
    logic [7:0]         data_byte = 8'd0;
    logic               send_last = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [1:0]         kind;
    logic [7:0]         out_byte;
    logic [5:0]         frame_length;
    logic               tx_int_enable;
    logic               last;

    int mismatches;
    int pending;
    int gap_pct = 0;
    int stall_pct = 0;
    int beat_count = 0;
    int quiet_cycles = 0;

    half_duplex_uart_bus_controller_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .data_byte     (data_byte),
        .send_last     (send_last),
        .empty         (empty),
        .pop           (pop),
        .kind          (kind),
        .out_byte      (out_byte),
        .frame_length  (frame_length),
        .tx_int_enable (tx_int_enable),
        .last          (last)
    );

    hdub_bus_checker i_bus_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .data_byte     (data_byte),
        .send_last     (send_last),
        .empty         (empty),
        .pop           (pop),
        .kind          (kind),
        .out_byte      (out_byte),
        .frame_length  (frame_length),
        .tx_int_enable (tx_int_enable),
        .last          (last),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        pop <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("half_duplex_uart_bus_controller_top: mismatch");
                $finish;
            end
        end
    end

    task automatic put_beat(hdub_pkg::cmd_t c, logic [7:0] d, logic l);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        cmd       <= c;
        data_byte <= d;
        send_last <= l;
        beat_count++;
        do @(posedge clk); while (full);
        @(negedge clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic random_phase(int target);
        int start_cnt;
        int len;
        int pick;
        int k;
        int n;
        start_cnt = beat_count;
        while (beat_count - start_cnt < target)
        begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                len = ($urandom_range(99) < 85) ? $urandom_range(6) : $urandom_range(36, 28);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(19) == 0)
                        put_beat(hdub_pkg::CMD_TX_EMPTY, 8'($urandom), 1'($urandom));
                    put_beat(hdub_pkg::CMD_RX_BYTE, 8'($urandom), 1'($urandom));
                end
                put_beat(hdub_pkg::CMD_LINE_IDLE, 8'($urandom), 1'($urandom));
            end else if (pick < 80) begin
                len = ($urandom_range(99) < 85) ? $urandom_range(6, 1) : $urandom_range(36, 30);
                for (k = 0; k < len; k++)
                    put_beat(hdub_pkg::CMD_SEND_BYTE, 8'($urandom), k == len - 1);
                if ($urandom_range(4) == 0) begin
                    n = $urandom_range(3, 1);
                    for (k = 0; k < n; k++)
                        put_beat(hdub_pkg::CMD_SEND_BYTE, 8'($urandom), k == n - 1);
                end
                n = ($urandom_range(9) == 0) ? $urandom_range(len) : len + 1;
                for (k = 0; k < n; k++)
                begin
                    if ($urandom_range(9) == 0)
                        put_beat(hdub_pkg::CMD_RX_BYTE, 8'($urandom), 1'($urandom));
                    put_beat(hdub_pkg::CMD_TX_EMPTY, 8'($urandom), 1'($urandom));
                end
            end else begin
                n = $urandom_range(4, 1);
                for (k = 0; k < n; k++)
                    put_beat(hdub_pkg::cmd_t'($urandom_range(3)), 8'($urandom),
                             1'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        put_beat(hdub_pkg::CMD_TX_EMPTY, 8'h00, 1'b0);
        put_beat(hdub_pkg::CMD_LINE_IDLE, 8'hFF, 1'b1);
        put_beat(hdub_pkg::CMD_RX_BYTE, 8'h00, 1'b1);
        put_beat(hdub_pkg::CMD_RX_BYTE, 8'hFF, 1'b0);
        put_beat(hdub_pkg::CMD_LINE_IDLE, 8'h00, 1'b0);
        put_beat(hdub_pkg::CMD_SEND_BYTE, 8'hFF, 1'b1);
        put_beat(hdub_pkg::CMD_SEND_BYTE, 8'h00, 1'b0);
        put_beat(hdub_pkg::CMD_SEND_BYTE, 8'h55, 1'b1);
        put_beat(hdub_pkg::CMD_TX_EMPTY, 8'hFF, 1'b1);
        put_beat(hdub_pkg::CMD_TX_EMPTY, 8'h00, 1'b0);
        put_beat(hdub_pkg::CMD_SEND_BYTE, 8'hA5, 1'b0);
        put_beat(hdub_pkg::CMD_SEND_BYTE, 8'h5A, 1'b1);
        put_beat(hdub_pkg::CMD_RX_BYTE, 8'h12, 1'b0);
        put_beat(hdub_pkg::CMD_LINE_IDLE, 8'h00, 1'b0);
        put_beat(hdub_pkg::CMD_TX_EMPTY, 8'h00, 1'b0);
        put_beat(hdub_pkg::CMD_TX_EMPTY, 8'h00, 1'b0);
        drain_results();

        random_phase(PHASE_BEATS);
        drain_results();
        gap_pct = 59;
        random_phase(PHASE_BEATS);
        drain_results();
        gap_pct   = 0;
        stall_pct = 59;
        random_phase(PHASE_BEATS);
        drain_results();
        gap_pct   = 15;
        stall_pct = 15;
        random_phase(PHASE_BEATS);
        drain_results();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("half_duplex_uart_bus_controller_top: match");
        else
            $display("half_duplex_uart_bus_controller_top: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/hdub_pkg.sv
rtl/core/hdub_front.sv
rtl/core/hdub_cmd_queue.sv
rtl/core/hdub_back.sv
rtl/core/half_duplex_uart_bus_controller_top.sv
sim/hdub_bus_checker.sv
sim/tb_half_duplex_uart_bus_controller_top.sv
